@@ rtl/lrupr_pkg.sv @@
`default_nettype none

package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;
    localparam int FAULT_W       = 32;
    localparam int RANK_W        = 8;
    localparam logic [RANK_W-1:0] RANK_CAP = 8'hFF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/lrupr_ctrl.sv @@
`default_nettype none

module lrupr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire lrupr_pkg::t_status i_status,
    output lrupr_pkg::t_cmd       o_cmd
);
    import lrupr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_status.scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_COMMIT: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/lrupr_datapath.sv @@
`default_nettype none

module lrupr_datapath #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int M_TDATA_W = ((SLOT_W + PAGE_BITS + lrupr_pkg::FAULT_W + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [lrupr_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic [PAGE_BITS-1:0]          i_page,
    input  wire logic                          i_last,
    input  wire lrupr_pkg::t_cmd               i_cmd,
    output lrupr_pkg::t_status                 o_status,
    output logic                               o_m_valid,
    input  wire logic                          i_m_ready,
    output logic [M_TDATA_W-1:0]               o_m_data,
    output logic [1:0]                         o_m_user,
    output logic                               o_m_last
);
    import lrupr_pkg::*;

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam logic [RANK_W:0] LIMIT_MISS = {1'b1, {RANK_W{1'b0}}};

    logic [CFG_W-1:0]     r_frames_in_use;
    logic [PAGE_BITS-1:0] r_in_page;
    logic                 r_in_last;
    logic [SLOT_W-1:0]    r_idx;

    logic                 r_p_vld;
    logic [SLOT_W-1:0]    r_p_idx;
    logic [PAGE_BITS-1:0] r_p_page;
    logic [RANK_W-1:0]    r_p_rank;

    logic                 r_hit;
    logic [SLOT_W-1:0]    r_hit_slot;
    logic [RANK_W-1:0]    r_hit_rank;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_best_idx;
    logic [RANK_W-1:0]    r_best_rank;
    logic [PAGE_BITS-1:0] r_best_page;

    logic [CNT_W-1:0]     r_filled;
    logic [FAULT_W-1:0]   r_fault;
    logic [RANK_W-1:0]    r_rank [FRAMES];
    logic [RANK_W-1:0]    n_rank [FRAMES];
    logic [PAGE_BITS-1:0] mem_page [FRAMES];

    logic                 r_out_valid;
    logic                 r_out_fault;
    logic [SLOT_W-1:0]    r_out_slot;
    logic                 r_out_evict;
    logic [PAGE_BITS-1:0] r_out_evpage;
    logic [FAULT_W-1:0]   r_out_count;
    logic                 r_out_last;

    logic [CNT_W-1:0]     w_n;
    logic                 w_p_valid;
    logic                 w_fill;
    logic [SLOT_W-1:0]    w_slot;
    logic [RANK_W:0]      w_limit;
    logic                 w_evict;
    logic [FAULT_W-1:0]   w_fault_next;

    always_comb begin
        if (r_frames_in_use == '0) begin
            w_n = CNT_W'(1);
        end else if (int'(r_frames_in_use) > FRAMES) begin
            w_n = CNT_W'(FRAMES);
        end else begin
            w_n = CNT_W'(r_frames_in_use);
        end
    end

    assign o_status.scan_last = (CNT_W'(CNT_W'(r_idx) + CNT_W'(1)) == w_n);
    assign o_status.out_free  = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_in_use <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_frames_in_use <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_page <= i_page;
            r_in_last <= i_last;
        end
        if (i_cmd.load) begin
            r_idx <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= SLOT_W'(r_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            r_p_page <= mem_page[r_idx];
        end
        if (i_cmd.commit && !r_hit) begin
            mem_page[w_slot] <= r_in_page;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_idx  <= r_idx;
        r_p_rank <= r_rank[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.scan;
        end
    end

    assign w_p_valid = r_p_vld && (CNT_W'(r_p_idx) < r_filled);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit   <= 1'b0;
            r_found <= 1'b0;
        end else if (w_p_valid) begin
            if (!r_hit && (r_p_page == r_in_page)) begin
                r_hit      <= 1'b1;
                r_hit_slot <= r_p_idx;
                r_hit_rank <= r_p_rank;
            end
            if (!r_found || (r_p_rank > r_best_rank)) begin
                r_found     <= 1'b1;
                r_best_idx  <= r_p_idx;
                r_best_rank <= r_p_rank;
                r_best_page <= r_p_page;
            end
        end
    end

    assign w_fill  = !r_hit && (r_filled < w_n);
    assign w_evict = !r_hit && !w_fill && r_found;
    assign w_limit = r_hit ? {1'b0, r_hit_rank} : LIMIT_MISS;

    always_comb begin
        if (r_hit) begin
            w_slot = r_hit_slot;
        end else if (w_fill) begin
            w_slot = SLOT_W'(r_filled);
        end else begin
            w_slot = r_best_idx;
        end
    end

    assign w_fault_next = (!r_hit && (r_fault != '1)) ? FAULT_W'(r_fault + 1'b1) : r_fault;

    always_comb begin
        for (int i = 0; i < FRAMES; i++) begin
            n_rank[i] = r_rank[i];
            if (SLOT_W'(i) == w_slot) begin
                n_rank[i] = '0;
            end else if ((CNT_W'(i) < w_n) && (CNT_W'(i) < r_filled) &&
                         ({1'b0, r_rank[i]} < w_limit) && (r_rank[i] != RANK_CAP)) begin
                n_rank[i] = RANK_W'(r_rank[i] + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_fault  <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_in_last) begin
                r_filled <= '0;
                r_fault  <= '0;
                for (int i = 0; i < FRAMES; i++) begin
                    r_rank[i] <= '0;
                end
            end else begin
                r_filled <= w_fill ? CNT_W'(r_filled + 1'b1) : r_filled;
                r_fault  <= w_fault_next;
                for (int i = 0; i < FRAMES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_fault  <= !r_hit;
            r_out_slot   <= w_slot;
            r_out_evict  <= w_evict;
            r_out_evpage <= w_evict ? r_best_page : '0;
            r_out_count  <= w_fault_next;
            r_out_last   <= r_in_last;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = M_TDATA_W'({r_out_count, r_out_evpage, r_out_slot});
    assign o_m_user  = {r_out_evict, r_out_fault};
    assign o_m_last  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/lru_page_replacement_unit.sv @@
// An accepted beat is loaded, then the frame scan reads one frame per cycle over the frames
// managed (FRAMES_MANAGED, the clamped frames_in_use value), then a drain state passes.
// The result is committed to the output register once that register is free; the next beat
// is taken only after that commit; the result waits there while the next beat is taken in.
// Reset is synchronous and active low; it empties all frames, clears the fault count
// and sets frames_in_use to eight. No clearing pass follows reset.
`default_nettype none

module lru_page_replacement_unit #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int S_TDATA_W = ((PAGE_BITS + 7) / 8) * 8,
    parameter int M_TDATA_W = ((SLOT_W + PAGE_BITS + lrupr_pkg::FAULT_W + 7) / 8) * 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [lrupr_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // page_number
    input  wire logic [S_TDATA_W-1:0]        s_axis_tdata,
    input  wire logic                        s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // slot_used, evicted_page, fault_count
    output logic [M_TDATA_W-1:0]             m_axis_tdata,
    // page_fault, evicted_valid
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import lrupr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = i_rst_n;

    lrupr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lrupr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .SLOT_W    (SLOT_W),
        .M_TDATA_W (M_TDATA_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_page      (s_axis_tdata[PAGE_BITS-1:0]),
        .i_last      (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_axis_tdata),
        .o_m_user    (m_axis_tuser),
        .o_m_last    (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/lrupr_checker.sv @@
`default_nettype none

module lrupr_checker #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
    parameter int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int M_TDATA_W = ((SLOT_W + PAGE_BITS + lrupr_pkg::FAULT_W + 7) / 8) * 8
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]           m_axis_tuser
);
    import lrupr_pkg::*;

    localparam int EVP_LO = SLOT_W;
    localparam int CNT_LO = SLOT_W + PAGE_BITS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("hit reported an eviction");

    a_evpage_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[EVP_LO +: PAGE_BITS] == '0)
        else $error("evicted page nonzero without eviction");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[CNT_LO +: FAULT_W] != '0)
        else $error("fault count zero on a result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while a beat is in progress");

endmodule

bind lru_page_replacement_unit lrupr_checker #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .SLOT_W    (SLOT_W),
    .M_TDATA_W (M_TDATA_W)
) u_lrupr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/tb_lru_page_replacement_unit.sv @@
`default_nettype none

module tb_lru_page_replacement_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_W         = 16;
    localparam int FRAME_CAP      = 8;
    localparam int M_W            = 56;
    localparam int USER_FAULT     = 0;
    localparam int USER_EVICT     = 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;

    typedef struct {
        logic              fault;
        logic [2:0]        slot;
        logic              evicted;
        logic [PAGE_W-1:0] evicted_page;
        logic [31:0]       faults;
        logic              done;
    } t_lru_outcome;

    class lru_frame_tracker;
        logic [PAGE_W-1:0]             page_of [FRAME_CAP];
        bit                            held [FRAME_CAP];
        int unsigned                   age_of [FRAME_CAP];
        int unsigned                   fill_level;
        logic [31:0]                   fault_total;
        logic [lrupr_pkg::CFG_W-1:0]   frames_reg;
        t_lru_outcome                  awaited [$];
        int                            mismatches;

        function new();
            clear_frames();
            frames_reg = lrupr_pkg::CFG_RESET;
            mismatches = 0;
        endfunction

        function void clear_frames();
            foreach (page_of[i]) begin
                page_of[i] = '0;
                held[i]    = 1'b0;
                age_of[i]  = 0;
            end
            fill_level  = 0;
            fault_total = '0;
        endfunction

        function int unsigned managed();
            if (frames_reg == 0) return 1;
            if (frames_reg > FRAME_CAP) return FRAME_CAP;
            return frames_reg;
        endfunction

        // Every other valid frame younger than the limit grows one step older, up to RANK_CAP.
        function void refresh(int unsigned k, int unsigned n, int unsigned limit);
            for (int unsigned i = 0; i < n; i++) begin
                if (i != k && held[i] && age_of[i] < limit && age_of[i] < lrupr_pkg::RANK_CAP)
                    age_of[i]++;
            end
            age_of[k] = 0;
        endfunction

        function void note_reference(logic [PAGE_W-1:0] page, logic last);
            int unsigned  n;
            int unsigned  slot;
            int unsigned  victim;
            bit           hit;
            bit           found;
            t_lru_outcome res;
            n = managed();
            slot = 0;
            hit = 1'b0;
            res.evicted = 1'b0;
            res.evicted_page = '0;
            for (int unsigned i = 0; i < n; i++) begin
                if (!hit && held[i] && page_of[i] == page) begin
                    hit = 1'b1;
                    slot = i;
                end
            end
            if (hit) begin
                refresh(slot, n, age_of[slot]);
            end else begin
                if (fill_level < n) begin
                    slot = fill_level;
                    fill_level++;
                end else begin
                    victim = 0;
                    found = 1'b0;
                    for (int unsigned i = 0; i < n; i++) begin
                        if (held[i] && (!found || age_of[i] > age_of[victim])) begin
                            victim = i;
                            found = 1'b1;
                        end
                    end
                    slot = victim;
                    if (held[slot]) begin
                        res.evicted = 1'b1;
                        res.evicted_page = page_of[slot];
                    end
                end
                held[slot] = 1'b1;
                page_of[slot] = page;
                refresh(slot, n, 256);
                if (fault_total != 32'hFFFF_FFFF)
                    fault_total++;
            end
            res.fault = !hit;
            res.slot = slot[2:0];
            res.faults = fault_total;
            res.done = last;
            awaited.push_back(res);
            if (last)
                clear_frames();
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
            mismatches++;
        endtask

        task check_outcome(t_lru_outcome got);
            t_lru_outcome want;
            if (awaited.size() == 0) begin
                report("unexpected beat", 32'd1, 32'd0);
            end else begin
                want = awaited.pop_front();
                if (got.fault !== want.fault)
                    report("page_fault", 32'(got.fault), 32'(want.fault));
                if (got.slot !== want.slot)
                    report("slot_used", 32'(got.slot), 32'(want.slot));
                if (got.evicted !== want.evicted)
                    report("evicted_valid", 32'(got.evicted), 32'(want.evicted));
                if (got.evicted_page !== want.evicted_page)
                    report("evicted_page", 32'(got.evicted_page), 32'(want.evicted_page));
                if (got.faults !== want.faults) report("fault_count", got.faults, want.faults);
                if (got.done !== want.done)
                    report("string_done", 32'(got.done), 32'(want.done));
            end
        endtask
    endclass

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [lrupr_pkg::CFG_W-1:0] i_cfg_data;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [PAGE_W-1:0]           s_axis_tdata;
    logic                        s_axis_tlast;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [M_W-1:0]              m_axis_tdata;
    logic [1:0]                  m_axis_tuser;
    logic                        m_axis_tlast;

    bit               calm = 1'b0;
    int unsigned      idle_cycles = 0;
    lru_frame_tracker tracker = new();

    lru_page_replacement_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    always @(posedge i_clk) begin
        t_lru_outcome got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.fault        = m_axis_tuser[USER_FAULT];
            got.evicted      = m_axis_tuser[USER_EVICT];
            got.slot         = m_axis_tdata[2:0];
            got.evicted_page = m_axis_tdata[18:3];
            got.faults       = m_axis_tdata[50:19];
            got.done         = m_axis_tlast;
            tracker.check_outcome(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL lru_page_replacement_unit");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_ref(input logic [PAGE_W-1:0] page, input logic last);
        while (!calm && $urandom_range(0, 99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        tracker.note_reference(page, last);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        tracker.frames_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_strings(input int unsigned target);
        int unsigned       sent;
        int unsigned       len;
        int unsigned       pool_n;
        logic [PAGE_W-1:0] pool [$];
        logic [PAGE_W-1:0] pg;
        bit                fin;
        bit                closed;
        sent = 0;
        while (sent < target) begin
            pool.delete();
            pool_n = tracker.managed() + $urandom_range(0, 4);
            repeat (pool_n) pool.push_back(PAGE_W'($urandom()));
            len = $urandom_range(1, 40);
            if (len > target - sent) len = target - sent;
            closed = ($urandom_range(0, 99) < 90);
            for (int unsigned k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 85)
                    pg = pool[$urandom_range(0, pool.size() - 1)];
                else
                    pg = PAGE_W'($urandom());
                fin = (k == len - 1) ? closed : ($urandom_range(0, 99) < 2);
                send_ref(pg, fin);
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned cfg_plan [12] = '{1, 8, 0, 15, 2, 5, 9, 3, 7, 4, 6, 12};
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fill all eight frames at the reset setting, then evict.
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h0000, 1'b0);
        send_ref(16'hFFFF, 1'b0);
        send_ref(16'h1111, 1'b0);
        send_ref(16'h2222, 1'b0);
        send_ref(16'h3333, 1'b0);
        send_ref(16'h4444, 1'b0);
        send_ref(16'h5555, 1'b0);
        send_ref(16'h6666, 1'b0);
        send_ref(16'hAAAA, 1'b0);
        send_ref(16'h0000, 1'b0);
        drain();
        // Shrinking mid-string hides the upper frames; growing again brings back stale ranks.
        write_frames(4'd3);
        send_ref(16'hBBBB, 1'b0);
        send_ref(16'hCCCC, 1'b0);
        send_ref(16'h5555, 1'b0);
        drain();
        write_frames(4'd8);
        send_ref(16'hDDDD, 1'b0);
        send_ref(16'hEEEE, 1'b0);
        send_ref(16'h0123, 1'b1);
        send_ref(16'h0123, 1'b0);
        send_ref(16'h0123, 1'b1);
        drain();
        write_frames(4'd1);
        send_ref(16'h7777, 1'b0);
        send_ref(16'h7777, 1'b0);
        send_ref(16'h8888, 1'b1);

        foreach (cfg_plan[p]) begin
            drain();
            write_frames(lrupr_pkg::CFG_W'(cfg_plan[p]));
            calm = (p == 4);
            run_strings(160);
        end
        calm = 1'b0;
        drain();

        if (tracker.mismatches == 0) begin
            $display("PASS lru_page_replacement_unit");
        end else begin
            $display("FAIL lru_page_replacement_unit");
        end
        $finish;
    end

endmodule

`default_nettype wire
